/* hdl/sca_pkg.sv */
// Shared constants, types and codes of the sound channel allocator.
`timescale 1ns / 1ps
package sca_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int NUM_SOUNDS   = 64;
    localparam int CHAN_W       = 3;
    localparam int SND_W        = 6;
    localparam int OP_W         = 3;

    localparam logic [NUM_CHANNELS-1:0] CHAN_MASK = {NUM_CHANNELS{1'b1}};

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [SND_W-1:0]  t_sound;

    typedef enum logic [OP_W-1:0] {
        OP_GRAB           = 3'd0,
        OP_LOOKUP_SOUND   = 3'd1,
        OP_LOOKUP_CHANNEL = 3'd2,
        OP_CLEAR_SOUND    = 3'd3,
        OP_CLEAR_CHANNEL  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_DIRECT,
        S_SCAN_C,
        S_SCAN_S,
        S_APPLY
    } t_state;

endpackage

/* hdl/sca_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module sca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/sca_pick.sv */
// Channel choice for a grab of a sound that holds no channel yet.
`timescale 1ns / 1ps
module sca_pick import sca_pkg::*; (
    input  logic [NUM_CHANNELS-1:0] i_free,
    input  logic [NUM_CHANNELS-1:0] i_playing,
    input  t_chan                   i_last,
    output t_chan                   o_chan
);

    logic [NUM_CHANNELS-1:0] cand_a;
    logic [NUM_CHANNELS-1:0] cand_b;
    t_chan                   pick_a;
    t_chan                   pick_b;

    always_comb begin
        cand_a = i_free & ~i_playing & CHAN_MASK;
        cand_b = ~i_playing & CHAN_MASK;
        pick_a = '0;
        pick_b = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (cand_a[i]) begin
                pick_a = t_chan'(i);
            end
            if (cand_b[i]) begin
                pick_b = t_chan'(i);
            end
        end
        if (|cand_a) begin
            o_chan = pick_a;
        end else if (|cand_b) begin
            o_chan = pick_b;
        end else if (i_last == t_chan'(NUM_CHANNELS - 1)) begin
            o_chan = '0;
        end else begin
            o_chan = i_last + t_chan'(1);
        end
    end

endmodule

/* hdl/sound_channel_allocator_unit.sv */
// Top level of the sound channel allocator: sequencer, map storage and result register.
`timescale 1ns / 1ps
// The unit takes one word at a time and holds o_stall high until that word's result
// has been built. A word whose direct map entry is set goes straight to apply, a sound
// after one read of the sound map RAM. A sound whose entry is empty scans up to eight
// channel entries, one per cycle; a channel whose entry is empty scans up to all 64
// sound entries through the single read port of the sound map RAM, one per cycle.
// The result sits in an output register, so the next word is accepted while it waits.
module sound_channel_allocator_unit import sca_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic [5:0]  i_sound_id,
    input  logic [2:0]  i_channel,
    input  logic [7:0]  i_playing_mask,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic [2:0]  o_channel_out,
    output logic [5:0]  o_sound_out
);

    t_state                  r_state, n_state;
    logic [OP_W-1:0]         r_op, n_op;
    t_sound                  r_snd, n_snd;
    t_chan                   r_ch, n_ch;
    logic [NUM_CHANNELS-1:0] r_play, n_play;
    t_sound                  r_idx, n_idx;
    logic                    r_cmp_vld, n_cmp_vld;
    t_sound                  r_cmp_idx, n_cmp_idx;
    logic                    r_found, n_found;
    t_sound                  r_x, n_x;
    logic [NUM_SOUNDS-1:0]   r_s2c_vld, n_s2c_vld;
    logic [NUM_CHANNELS-1:0] r_c2s_vld, n_c2s_vld;
    t_sound                  r_c2s_snd [NUM_CHANNELS];
    t_sound                  n_c2s_snd [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_free, n_free;
    t_chan                   r_last, n_last;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_hit, n_out_hit;
    t_chan                   r_out_ch, n_out_ch;
    t_sound                  r_out_snd, n_out_snd;

    logic   snd_ok;
    logic   ch_ok;
    logic   sel_snd;
    logic   sel_ch;
    logic   apply_go;
    t_chan  c2s_addr;
    logic   c2s_vld_rd;
    t_sound c2s_snd_rd;
    logic   c2s_match;
    logic   s2c_match;
    t_chan  ram_rdata;
    t_sound ram_addr;
    logic   ram_we;
    t_chan  pick_ch;
    t_chan  grab_ch;

    sca_ram #(
        .WIDTH (CHAN_W),
        .DEPTH (NUM_SOUNDS)
    ) u_s2c_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (grab_ch),
        .o_rdata (ram_rdata)
    );

    sca_pick u_pick (
        .i_free    (r_free),
        .i_playing (r_play),
        .i_last    (r_last),
        .o_chan    (pick_ch)
    );

    assign snd_ok  = ({1'b0, r_snd} < (SND_W + 1)'(NUM_SOUNDS));
    assign ch_ok   = ({1'b0, r_ch} < (CHAN_W + 1)'(NUM_CHANNELS));
    assign sel_snd = snd_ok && (r_op == OP_GRAB || r_op == OP_LOOKUP_SOUND
                                || r_op == OP_CLEAR_SOUND);
    assign sel_ch  = ch_ok && (r_op == OP_LOOKUP_CHANNEL || r_op == OP_CLEAR_CHANNEL);

    assign apply_go = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    assign c2s_addr   = (r_state == S_SCAN_C) ? r_idx[CHAN_W-1:0] : r_ch;
    assign c2s_vld_rd = r_c2s_vld[c2s_addr];
    assign c2s_snd_rd = r_c2s_snd[c2s_addr];
    assign c2s_match  = c2s_vld_rd && (c2s_snd_rd == r_snd);
    assign s2c_match  = r_cmp_vld && r_s2c_vld[r_cmp_idx] && (ram_rdata == r_ch);

    assign grab_ch  = r_found ? r_x[CHAN_W-1:0] : pick_ch;
    assign ram_addr = (r_state == S_SCAN_S) ? r_idx : r_snd;
    assign ram_we   = (r_state == S_APPLY) && apply_go && snd_ok && (r_op == OP_GRAB);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sel_snd) begin
                    n_state = r_s2c_vld[r_snd] ? S_RD_DIRECT : S_SCAN_C;
                end else if (sel_ch) begin
                    n_state = c2s_vld_rd ? S_APPLY : S_SCAN_S;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_RD_DIRECT: begin
                n_state = S_APPLY;
            end
            S_SCAN_C: begin
                if (c2s_match || r_idx[CHAN_W-1:0] == t_chan'(NUM_CHANNELS - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_SCAN_S: begin
                if (s2c_match || (r_cmp_vld && r_cmp_idx == t_sound'(NUM_SOUNDS - 1))) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (apply_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_op        = r_op;
        n_snd       = r_snd;
        n_ch        = r_ch;
        n_play      = r_play;
        n_idx       = r_idx;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_found     = r_found;
        n_x         = r_x;
        n_s2c_vld   = r_s2c_vld;
        n_c2s_vld   = r_c2s_vld;
        n_c2s_snd   = r_c2s_snd;
        n_free      = r_free;
        n_last      = r_last;
        n_out_hit   = r_out_hit;
        n_out_ch    = r_out_ch;
        n_out_snd   = r_out_snd;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_operation;
                    n_snd   = i_sound_id;
                    n_ch    = i_channel;
                    n_play  = i_playing_mask & CHAN_MASK;
                    n_found = 1'b0;
                    n_x     = '0;
                end
            end
            S_DISPATCH: begin
                n_idx     = '0;
                n_cmp_vld = 1'b0;
                if (sel_ch && c2s_vld_rd) begin
                    n_found = 1'b1;
                    n_x     = c2s_snd_rd;
                end
            end
            S_RD_DIRECT: begin
                n_found = 1'b1;
                n_x     = {{(SND_W - CHAN_W){1'b0}}, ram_rdata};
            end
            S_SCAN_C: begin
                if (c2s_match) begin
                    n_found = 1'b1;
                    n_x     = r_idx;
                end else begin
                    n_idx = r_idx + t_sound'(1);
                end
            end
            S_SCAN_S: begin
                if (s2c_match) begin
                    n_found = 1'b1;
                    n_x     = r_cmp_idx;
                end else begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx;
                    n_idx     = r_idx + t_sound'(1);
                end
            end
            S_APPLY: begin
                if (apply_go) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = 1'b0;
                    n_out_ch    = '0;
                    n_out_snd   = '0;
                    if (sel_snd && r_op == OP_GRAB) begin
                        if (!r_found) begin
                            n_last = pick_ch;
                        end
                        n_free[grab_ch]    = 1'b0;
                        n_s2c_vld[r_snd]   = 1'b1;
                        n_c2s_vld[grab_ch] = 1'b1;
                        n_c2s_snd[grab_ch] = r_snd;
                        n_out_hit          = 1'b1;
                        n_out_ch           = grab_ch;
                    end else if (sel_snd && r_op == OP_LOOKUP_SOUND) begin
                        n_out_hit = r_found;
                        n_out_ch  = r_found ? r_x[CHAN_W-1:0] : '0;
                    end else if (sel_ch && r_op == OP_LOOKUP_CHANNEL) begin
                        n_out_hit = r_found;
                        n_out_snd = r_found ? r_x : '0;
                    end else if (sel_snd && r_op == OP_CLEAR_SOUND) begin
                        n_s2c_vld[r_snd] = 1'b0;
                        if (r_found) begin
                            n_c2s_vld[r_x[CHAN_W-1:0]] = 1'b0;
                            n_free[r_x[CHAN_W-1:0]]    = 1'b1;
                        end
                    end else if (sel_ch && r_op == OP_CLEAR_CHANNEL) begin
                        n_c2s_vld[r_ch] = 1'b0;
                        if (r_found) begin
                            n_s2c_vld[r_x] = 1'b0;
                        end
                        n_free[r_ch] = 1'b1;
                    end
                end
            end
            default: begin
                n_found = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_s2c_vld   <= '0;
            r_c2s_vld   <= '0;
            r_free      <= CHAN_MASK;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= n_cmp_vld;
            r_s2c_vld   <= n_s2c_vld;
            r_c2s_vld   <= n_c2s_vld;
            r_free      <= n_free;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_snd     <= n_snd;
        r_ch      <= n_ch;
        r_play    <= n_play;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_found   <= n_found;
        r_x       <= n_x;
        r_c2s_snd <= n_c2s_snd;
        r_out_hit <= n_out_hit;
        r_out_ch  <= n_out_ch;
        r_out_snd <= n_out_snd;
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_channel_out = r_out_ch;
    assign o_sound_out   = r_out_snd;

endmodule

/* sim/sound_channel_allocator_unit_tb.sv */
// Self-checking testbench for the sound channel allocator, with a directed table and random words.
`timescale 1ns / 1ps
module sound_channel_allocator_unit_tb;
    import sca_pkg::*;

    localparam logic [2:0] OP_RSVD_A = 3'd5;
    localparam logic [2:0] OP_RSVD_B = 3'd6;
    localparam logic [2:0] OP_RSVD_C = 3'd7;

    localparam int RANDOM_WORDS = 450;
    localparam int CALM_FIRST   = 150;
    localparam int CALM_LAST    = 249;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic   hit;
        t_chan  ch;
        t_sound snd;
    } t_voice_result;

    typedef struct packed {
        logic [2:0]    op;
        t_sound        snd;
        t_chan         ch;
        logic [7:0]    mask;
        logic          typed;
        t_voice_result fixed;
    } t_stim_row;

    localparam int NUM_ROWS = 25;

    // Rows with typed set carry their own expected word; the rest go to the predictor.
    localparam t_stim_row DIRECTED [NUM_ROWS] = '{
        '{OP_LOOKUP_SOUND,   6'd0,  3'd0, 8'h00, 1'b1, '{1'b0, 3'd0, 6'd0}},
        '{OP_LOOKUP_CHANNEL, 6'd0,  3'd7, 8'h00, 1'b1, '{1'b0, 3'd0, 6'd0}},
        '{OP_LOOKUP_CHANNEL, 6'd0,  3'd0, 8'h00, 1'b1, '{1'b0, 3'd0, 6'd0}},
        '{OP_GRAB,           6'd0,  3'd0, 8'h00, 1'b1, '{1'b1, 3'd0, 6'd0}},
        '{OP_GRAB,           6'd63, 3'd0, 8'h01, 1'b0, '0},
        '{OP_GRAB,           6'd63, 3'd0, 8'hFF, 1'b0, '0},
        '{OP_LOOKUP_CHANNEL, 6'd0,  3'd1, 8'h00, 1'b0, '0},
        '{OP_LOOKUP_SOUND,   6'd63, 3'd0, 8'h00, 1'b0, '0},
        '{OP_GRAB,           6'd10, 3'd0, 8'h00, 1'b0, '0},
        '{OP_GRAB,           6'd11, 3'd0, 8'h00, 1'b0, '0},
        '{OP_GRAB,           6'd12, 3'd0, 8'h00, 1'b0, '0},
        '{OP_GRAB,           6'd13, 3'd0, 8'h00, 1'b0, '0},
        '{OP_GRAB,           6'd14, 3'd0, 8'h00, 1'b0, '0},
        '{OP_GRAB,           6'd15, 3'd0, 8'h00, 1'b0, '0},
        '{OP_GRAB,           6'd20, 3'd0, 8'hFE, 1'b0, '0},
        '{OP_GRAB,           6'd21, 3'd0, 8'hFF, 1'b0, '0},
        '{OP_LOOKUP_SOUND,   6'd0,  3'd0, 8'h00, 1'b0, '0},
        '{OP_LOOKUP_CHANNEL, 6'd0,  3'd0, 8'h00, 1'b0, '0},
        '{OP_CLEAR_SOUND,    6'd0,  3'd0, 8'h00, 1'b1, '{1'b0, 3'd0, 6'd0}},
        '{OP_LOOKUP_CHANNEL, 6'd0,  3'd0, 8'h00, 1'b0, '0},
        '{OP_CLEAR_CHANNEL,  6'd0,  3'd7, 8'h00, 1'b1, '{1'b0, 3'd0, 6'd0}},
        '{OP_LOOKUP_CHANNEL, 6'd0,  3'd7, 8'h00, 1'b0, '0},
        '{OP_RSVD_A,         6'd63, 3'd7, 8'hFF, 1'b1, '{1'b0, 3'd0, 6'd0}},
        '{OP_RSVD_B,         6'd21, 3'd1, 8'h00, 1'b1, '{1'b0, 3'd0, 6'd0}},
        '{OP_RSVD_C,         6'd0,  3'd0, 8'hAA, 1'b1, '{1'b0, 3'd0, 6'd0}}
    };

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic [2:0] i_operation    = '0;
    logic [5:0] i_sound_id     = '0;
    logic [2:0] i_channel      = '0;
    logic [7:0] i_playing_mask = '0;
    logic       i_stall        = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_hit;
    logic [2:0] o_channel_out;
    logic [5:0] o_sound_out;

    logic   snd_map_valid [NUM_SOUNDS];
    t_chan  snd_map       [NUM_SOUNDS];
    logic   chan_map_valid [NUM_CHANNELS];
    t_sound chan_map       [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] free_mask;
    t_chan  last_grant;

    t_voice_result pending_results [$];

    bit calm = 1'b0;
    int errors = 0;
    int results_checked = 0;
    int hits_seen = 0;
    int quiet_cycles = 0;
    int words_by_op [8] = '{default: 0};

    sound_channel_allocator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_sound_id     (i_sound_id),
        .i_channel      (i_channel),
        .i_playing_mask (i_playing_mask),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hit          (o_hit),
        .o_channel_out  (o_channel_out),
        .o_sound_out    (o_sound_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit channel_of_sound(input t_sound snd, output t_chan ch);
        ch = '0;
        if (snd_map_valid[snd]) begin
            ch = snd_map[snd];
            return 1'b1;
        end
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (chan_map_valid[i] && chan_map[i] == snd) begin
                ch = t_chan'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit sound_of_channel(input t_chan ch, output t_sound snd);
        snd = '0;
        if (chan_map_valid[ch]) begin
            snd = chan_map[ch];
            return 1'b1;
        end
        for (int i = 0; i < NUM_SOUNDS; i++) begin
            if (snd_map_valid[i] && snd_map[i] == ch) begin
                snd = t_sound'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_voice_result predict_voice_result(input logic [2:0] op, input t_sound snd,
                                                           input t_chan ch, input logic [7:0] mask);
        t_voice_result r;
        t_chan         pick;
        t_sound        who;
        bit            found;
        r = '0;
        case (op)
            OP_GRAB: begin
                if (!channel_of_sound(snd, pick)) begin
                    found = 1'b0;
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (!found && free_mask[i] && !mask[i]) begin
                            pick  = t_chan'(i);
                            found = 1'b1;
                        end
                    end
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (!found && !mask[i]) begin
                            pick  = t_chan'(i);
                            found = 1'b1;
                        end
                    end
                    // With every channel playing, the one after the last grant is stolen.
                    if (!found) begin
                        pick = t_chan'((int'(last_grant) + 1) % NUM_CHANNELS);
                    end
                    last_grant = pick;
                end
                free_mask[pick]      = 1'b0;
                snd_map_valid[snd]   = 1'b1;
                snd_map[snd]         = pick;
                chan_map_valid[pick] = 1'b1;
                chan_map[pick]       = snd;
                r.hit = 1'b1;
                r.ch  = pick;
            end
            OP_LOOKUP_SOUND: begin
                if (channel_of_sound(snd, pick)) begin
                    r.hit = 1'b1;
                    r.ch  = pick;
                end
            end
            OP_LOOKUP_CHANNEL: begin
                if (sound_of_channel(ch, who)) begin
                    r.hit = 1'b1;
                    r.snd = who;
                end
            end
            OP_CLEAR_SOUND: begin
                found = channel_of_sound(snd, pick);
                snd_map_valid[snd] = 1'b0;
                if (found) begin
                    chan_map_valid[pick] = 1'b0;
                    free_mask[pick]      = 1'b1;
                end
            end
            OP_CLEAR_CHANNEL: begin
                found = sound_of_channel(ch, who);
                chan_map_valid[ch] = 1'b0;
                if (found) begin
                    snd_map_valid[who] = 1'b0;
                end
                free_mask[ch] = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(input logic [2:0] op, input t_sound snd, input t_chan ch,
                             input logic [7:0] mask, input bit typed, input t_voice_result fixed);
        t_voice_result r;
        while (!calm && $urandom_range(0, 99) < 11) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_sound_id     <= snd;
        i_channel      <= ch;
        i_playing_mask <= mask;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        r = predict_voice_result(op, snd, ch, mask);
        pending_results.push_back(typed ? fixed : r);
        words_by_op[op]++;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string what, input int expv, input int actv);
        if (expv != actv) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, expv, actv);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 11);
    end

    always @(posedge i_clk) begin
        t_voice_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got hit %0d ch %0d snd %0d",
                         $time, o_hit, o_channel_out, o_sound_out);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", want.hit, o_hit);
                check_field("channel_out", want.ch, o_channel_out);
                check_field("sound_out", want.snd, o_sound_out);
                results_checked++;
                if (o_hit) begin
                    hits_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [2:0] op;
        t_sound     snd;
        int         pick;
        logic [7:0] mask;
        for (int i = 0; i < NUM_SOUNDS; i++) begin
            snd_map_valid[i] = 1'b0;
            snd_map[i]       = '0;
        end
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_map_valid[i] = 1'b0;
            chan_map[i]       = '0;
        end
        free_mask  = CHAN_MASK;
        last_grant = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            send_word(DIRECTED[r].op, DIRECTED[r].snd, DIRECTED[r].ch, DIRECTED[r].mask,
                      DIRECTED[r].typed, DIRECTED[r].fixed);
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= CALM_FIRST && n <= CALM_LAST);
            pick = $urandom_range(0, 99);
            if (pick < 35)      op = OP_GRAB;
            else if (pick < 50) op = OP_LOOKUP_SOUND;
            else if (pick < 65) op = OP_LOOKUP_CHANNEL;
            else if (pick < 77) op = OP_CLEAR_SOUND;
            else if (pick < 89) op = OP_CLEAR_CHANNEL;
            else                op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
            // A small pool of sounds keeps the maps busy enough for hits and steals.
            snd = ($urandom_range(0, 9) < 7) ? t_sound'($urandom_range(0, 11))
                                             : t_sound'($urandom_range(0, NUM_SOUNDS - 1));
            case ($urandom_range(0, 3))
                0:       mask = 8'h00;
                1:       mask = 8'hFF;
                default: mask = 8'($urandom_range(0, 255));
            endcase
            send_word(op, snd, t_chan'($urandom_range(0, NUM_CHANNELS - 1)), mask, 1'b0, '0);
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words: %0d grabs, %0d sound and %0d channel lookups, %0d clears, %0d spare codes.",
                 NUM_ROWS + RANDOM_WORDS, words_by_op[OP_GRAB], words_by_op[OP_LOOKUP_SOUND],
                 words_by_op[OP_LOOKUP_CHANNEL],
                 words_by_op[OP_CLEAR_SOUND] + words_by_op[OP_CLEAR_CHANNEL],
                 words_by_op[OP_RSVD_A] + words_by_op[OP_RSVD_B] + words_by_op[OP_RSVD_C]);
        $display("Checked %0d result words, %0d of them hits, with %0d mismatches.",
                 results_checked, hits_seen, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
